>>> sv/tsp_pkg.sv
// Shared types, widths, coefficient table and rounding helper for the Taylor sine pipeline.
package tsp_pkg;

    // Internal fixed point: FRAC fraction bits in every field of the word passed down the chain.
    localparam int FRAC     = 24;
    localparam int ANGLE_W  = 16;
    localparam int SINE_W   = 16;
    localparam int IN_FRAC  = 13;
    localparam int OUT_FRAC = 13;

    // Angle widened to FRAC fraction bits (at most 8.0 radians).
    localparam int TH_W   = ANGLE_W + FRAC - IN_FRAC;
    // Square of the angle, up to 64.0, needs one more integer bit.
    localparam int TH2_W  = 2 * TH_W - FRAC + 1;
    // Horner coefficients are all below one.
    localparam int COEF_W = FRAC;
    // Product theta^2*coef stays below 16.0.
    localparam int T_W    = FRAC + 5;
    // Running Horner value, signed, with headroom of several integer bits.
    localparam int VAL_W  = FRAC + 8;
    // Number of Horner steps.
    localparam int STEPS  = 6;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
    localparam logic signed [63:0] SAT_MAX = 64'sd32767;
    localparam logic signed [63:0] SAT_MIN = -64'sd32768;

    // Reciprocals 1/n held in Q.30, rounded to nearest, paired per step.
    localparam longint unsigned RECIP_Q30 [12] = '{
        64'd89478485,  64'd82595525,
        64'd107374182, 64'd97612893,
        64'd134217728, 64'd119304647,
        64'd178956971, 64'd153391689,
        64'd268435456, 64'd214748365,
        64'd536870912, 64'd357913941
    };

    // One word as it moves down the chain.
    typedef struct packed {
        logic                    last;
        logic [TH_W-1:0]         theta;
        logic [TH2_W-1:0]        theta2;
        logic signed [VAL_W-1:0] val;
    } tsp_word_t;

    // Coefficient of Horner step k: product of two reciprocals brought to Q.FRAC.
    function automatic logic [COEF_W-1:0] coef_q(input int k);
        longint unsigned prod;
        longint unsigned rnd;
        prod = RECIP_Q30[2 * k] * RECIP_Q30[2 * k + 1];
        rnd  = (prod + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
        return rnd[COEF_W-1:0];
    endfunction

    // Shift a signed product right by sh, rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                     input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] q;
        mag = p[63] ? (~p + 64'd1) : p;
        q   = (mag + (64'd1 << (sh - 1))) >> sh;
        return p[63] ? $signed(~q + 64'd1) : $signed(q);
    endfunction

endpackage

>>> sv/taylor_sine_polynomial.sv
// Top level: Taylor sine through x^13 as a chain of Horner cells.
//
// Input channel (s_valid/s_ready): one word per angle, s_angle in unsigned
// Q3.13 radians and s_last_in marking the final element of a vector.
// Output channel (m_valid/m_ready): one word per input word, in order,
// m_sine in signed Q2.13 (saturated) and m_last_out copied from s_last_in.
// The chain has 15 register stages: one to square the angle, two in each
// of the six Horner cells (coefficient multiply, then value multiply),
// and two in the output stage (final multiply, then rounding and
// saturation into the output register). Throughput is one word per cycle
// while the receiver does not stall; every stage holds its own valid bit.
// When the receiver stalls, words keep moving up into empty stages behind
// the output register, and s_ready drops only once the whole chain is full.
// Synchronous active-low reset empties every stage; no clearing pass.
module taylor_sine_polynomial import tsp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ANGLE_W-1:0]       s_angle,
    input  logic                     s_last_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [SINE_W-1:0] m_sine,
    output logic                     m_last_out
);

    logic      vld   [STEPS+1];
    logic      rdy   [STEPS+1];
    tsp_word_t word  [STEPS+1];

    // Square of the angle.
    tsp_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .angle     (s_angle),
        .last_in   (s_last_in),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (word[0])
    );

    // Horner cells, innermost coefficient first.
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        localparam logic [COEF_W-1:0] CoefK = coef_q(g);
        tsp_horner_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coef      (CoefK),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_data   (word[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_data  (word[g+1])
        );
    end

    // Final multiply, rounding and saturation.
    tsp_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[STEPS]),
        .in_ready  (rdy[STEPS]),
        .in_data   (word[STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sine      (m_sine),
        .last_out  (m_last_out)
    );

endmodule

>>> sv/tsp_square.sv
// Entry stage: widens the angle and registers its square.
module tsp_square import tsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ANGLE_W-1:0] angle,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output tsp_word_t          out_data
);

    logic                    valid_reg;
    tsp_word_t               data_reg;
    tsp_word_t               data_next;
    logic [TH_W-1:0]         theta;
    logic [2*TH_W-1:0]       sq;
    logic signed [63:0]      sq_rnd;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Square the widened angle and start the Horner value at one.
    always_comb begin
        theta  = {angle, {(FRAC - IN_FRAC){1'b0}}};
        sq     = theta * theta;
        sq_rnd = rnd_shift($signed(64'(sq)), FRAC);
        data_next.last   = last_in;
        data_next.theta  = theta;
        data_next.theta2 = sq_rnd[TH2_W-1:0];
        data_next.val    = ONE[VAL_W-1:0];
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> sv/tsp_horner_cell.sv
// One Horner step: val = 1 - (theta^2 * coef) * val over two registered stages.
module tsp_horner_cell import tsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [COEF_W-1:0] coef,
    input  logic              in_valid,
    output logic              in_ready,
    input  tsp_word_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tsp_word_t         out_data
);

    logic                  a_valid_reg;
    tsp_word_t             a_data_reg;
    logic [T_W-1:0]        t_reg;
    logic [T_W-1:0]        t_next;
    logic                  b_valid_reg;
    tsp_word_t             b_data_reg;
    tsp_word_t             b_data_next;
    logic                  a_ready;
    logic                  b_ready;
    logic [TH2_W+COEF_W-1:0]     tc_prod;
    logic signed [63:0]          tc_rnd;
    logic signed [T_W+VAL_W:0]   tv_prod;
    logic signed [63:0]          tv_rnd;
    logic signed [63:0]          val_new;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    // First stage: scale the squared angle by this step's coefficient.
    always_comb begin
        tc_prod = in_data.theta2 * coef;
        tc_rnd  = rnd_shift($signed(64'(tc_prod)), FRAC);
        t_next  = tc_rnd[T_W-1:0];
    end

    // Second stage: multiply by the running value and subtract from one.
    always_comb begin
        tv_prod     = $signed({1'b0, t_reg}) * a_data_reg.val;
        tv_rnd      = rnd_shift(64'(tv_prod), FRAC);
        val_new     = ONE - tv_rnd;
        b_data_next = a_data_reg;
        b_data_next.val = val_new[VAL_W-1:0];
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
        if (in_valid && a_ready) begin
            a_data_reg <= in_data;
            t_reg      <= t_next;
        end
        if (a_valid_reg && b_ready) begin
            b_data_reg <= b_data_next;
        end
    end

    // A word held in the first stage keeps its scaled square while the second is blocked.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !b_ready |=> a_valid_reg && $stable(t_reg) && $stable(a_data_reg))
        else $error("first stage lost its word during a stall");

    // A blocked result stays in the second stage unchanged.
    b_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !out_ready |=> b_valid_reg && $stable(b_data_reg))
        else $error("second stage changed during a stall");

    // An accepted word always lands in the first stage.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> a_valid_reg)
        else $error("accepted word not captured");

endmodule

>>> sv/tsp_output.sv
// Final stage: theta * val, rounded to Q2.13 and saturated.
module tsp_output import tsp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tsp_word_t                in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SINE_W-1:0] sine,
    output logic                     last_out
);

    logic                        p_valid_reg;
    logic signed [TH_W+VAL_W:0]  p_reg;
    logic                        p_last_reg;
    logic                        o_valid_reg;
    logic signed [SINE_W-1:0]    sine_reg;
    logic signed [SINE_W-1:0]    sine_next;
    logic                        last_reg;
    logic                        p_ready;
    logic                        o_ready;
    logic signed [63:0]          s_rnd;

    assign o_ready   = !o_valid_reg || out_ready;
    assign p_ready   = !p_valid_reg || o_ready;
    assign in_ready  = p_ready;
    assign out_valid = o_valid_reg;
    assign sine      = sine_reg;
    assign last_out  = last_reg;

    // Round the product straight to the output format and clamp.
    always_comb begin
        s_rnd = rnd_shift(64'(p_reg), 2 * FRAC - OUT_FRAC);
        if (s_rnd > SAT_MAX) begin
            sine_next = SAT_MAX[SINE_W-1:0];
        end else if (s_rnd < SAT_MIN) begin
            sine_next = SAT_MIN[SINE_W-1:0];
        end else begin
            sine_next = s_rnd[SINE_W-1:0];
        end
    end

    // Product register and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (p_ready) begin
                p_valid_reg <= in_valid;
            end
            if (o_ready) begin
                o_valid_reg <= p_valid_reg;
            end
        end
        if (in_valid && p_ready) begin
            p_reg      <= $signed({1'b0, in_data.theta}) * in_data.val;
            p_last_reg <= in_data.last;
        end
        if (p_valid_reg && o_ready) begin
            sine_reg <= sine_next;
            last_reg <= p_last_reg;
        end
    end

endmodule

>>> tb/taylor_sine_polynomial_chk.sv
// Scoreboard for the Taylor sine pipeline: predicts each word and checks the output channel.
module taylor_sine_polynomial_chk import tsp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [ANGLE_W-1:0]       s_angle,
    input  logic                     s_last_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [SINE_W-1:0] m_sine,
    input  logic                     m_last_out,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic signed [SINE_W-1:0] sine;
        logic                     last;
    } sine_word_t;

    sine_word_t expected_sines[$];

    // Exact product of two signed values, shifted right by sh with rounding to
    // nearest (ties away from zero) and the magnitude clamped to the int64 range.
    function automatic longint mul_round(input longint a, input longint b,
                                         input int unsigned sh);
        logic         neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] prod;
        logic [127:0] q;
        longint       mag;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? 64'(-a) : 64'(a);
        mb   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ma} * {64'd0, mb};
        q    = (prod + (128'd1 << (sh - 1))) >> sh;
        if (q > 128'h7FFF_FFFF_FFFF_FFFF)
            q = 128'h7FFF_FFFF_FFFF_FFFF;
        mag = longint'(q[63:0]);
        return neg ? -mag : mag;
    endfunction

    // Horner evaluation of the sine series through x^13 for one angle.
    function automatic sine_word_t predict_sine(input logic [ANGLE_W-1:0] angle,
                                                input logic last);
        longint     one_q;
        longint     theta;
        longint     theta2;
        longint     val;
        longint     coef;
        longint     t;
        longint     u;
        longint     s;
        sine_word_t word;
        one_q  = longint'(1) <<< FRAC;
        theta  = longint'({48'd0, angle}) <<< (FRAC - IN_FRAC);
        theta2 = mul_round(theta, theta, FRAC);
        val    = one_q;
        for (int k = 0; k < STEPS; k++) begin
            coef = mul_round(longint'(RECIP_Q30[2 * k]), longint'(RECIP_Q30[2 * k + 1]),
                             60 - FRAC);
            t    = mul_round(theta2, coef, FRAC);
            u    = mul_round(t, val, FRAC);
            val  = one_q - u;
        end
        s = mul_round(theta, val, 2 * FRAC - OUT_FRAC);
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        word.sine = s[SINE_W-1:0];
        word.last = last;
        return word;
    endfunction

    // Retire expectations against outgoing words, then queue the new prediction.
    always @(posedge aclk) begin
        sine_word_t want;
        int         nbad;
        nbad = 0;
        if (!aresetn) begin
            expected_sines.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sines.size() == 0) begin
                    nbad++;
                    $display("%0t: unexpected word, expected none, got sine %0d last %0b",
                             $time, m_sine, m_last_out);
                end else begin
                    want = expected_sines.pop_front();
                    if (m_sine !== want.sine) begin
                        nbad++;
                        $display("%0t: sine mismatch, expected %0d, got %0d",
                                 $time, want.sine, m_sine);
                    end
                    if (m_last_out !== want.last) begin
                        nbad++;
                        $display("%0t: last_out mismatch, expected %0b, got %0b",
                                 $time, want.last, m_last_out);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_sines.push_back(predict_sine(s_angle, s_last_in));
            pending <= expected_sines.size();
            if (nbad != 0)
                errors <= errors + nbad;
        end
    end

endmodule

>>> tb/taylor_sine_polynomial_tb.sv
// Testbench top for the Taylor sine pipeline: clock, reset, traffic and verdict.
module taylor_sine_polynomial_tb import tsp_pkg::*;;

    typedef enum logic [1:0] {
        MODE_RANDOM,
        MODE_STEADY,
        MODE_BACKPRESSURE
    } traffic_mode_t;

    localparam logic [ANGLE_W-1:0] TWO_PI = 16'd51472;

    logic                     aclk       = 1'b0;
    logic                     aresetn    = 1'b0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [ANGLE_W-1:0]       s_angle    = '0;
    logic                     s_last_in  = 1'b0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic signed [SINE_W-1:0] m_sine;
    logic                     m_last_out;
    int                       errors;
    int                       pending;
    traffic_mode_t            mode       = MODE_RANDOM;
    int                       hold_left  = 0;
    logic                     held       = 1'b0;

    always #4 aclk = ~aclk;

    taylor_sine_polynomial u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_angle    (s_angle),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sine     (m_sine),
        .m_last_out (m_last_out)
    );

    taylor_sine_polynomial_chk u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_angle    (s_angle),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sine     (m_sine),
        .m_last_out (m_last_out),
        .errors     (errors),
        .pending    (pending)
    );

    // Receiver: random stalls, a steady stretch, and one long counted hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (mode == MODE_BACKPRESSURE && !held) begin
            m_ready   <= 1'b0;
            hold_left <= 63;
            held      <= 1'b1;
        end else if (mode != MODE_RANDOM) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 11);
        end
    end

    // Offer one word and hold it until accepted; a random gap may come first.
    task automatic send_word(input logic [ANGLE_W-1:0] angle, input logic last);
        if (mode == MODE_RANDOM && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 11);
        end
        s_valid   <= 1'b1;
        s_angle   <= angle;
        s_last_in <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly in-range angles, with some over the full 16-bit range.
    task automatic send_random(input int count);
        logic [ANGLE_W-1:0] angle;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80)
                angle = ANGLE_W'($urandom_range(int'(TWO_PI)));
            else
                angle = ANGLE_W'($urandom);
            send_word(angle, $urandom_range(7) == 0);
        end
    endtask

    // Sender idles until every predicted word has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, quadrant points, around two pi, and the field extremes.
        send_word(16'd0, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b1);
        send_word(16'd12868, 1'b0);
        send_word(16'd25736, 1'b0);
        send_word(16'd38604, 1'b1);
        send_word(TWO_PI - 16'd1, 1'b0);
        send_word(TWO_PI, 1'b1);
        send_word(TWO_PI + 16'd1, 1'b0);
        send_word(16'h5555, 1'b0);
        send_word(16'hAAAA, 1'b1);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'd60000, 1'b0);
        send_word(16'hFFFE, 1'b0);
        send_word(16'hFFFF, 1'b1);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering words.
        mode <= MODE_BACKPRESSURE;
        send_random(48);
        mode <= MODE_RANDOM;
        send_random(400);

        // Neither side idles here.
        mode <= MODE_STEADY;
        send_random(200);
        mode <= MODE_RANDOM;
        wait_drained();
        send_random(350);

        wait_drained();
        repeat (30) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("** taylor_sine_polynomial: PASSED **");
        end else begin
            $display("** taylor_sine_polynomial: FAILED **");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #800000;
        $display("** taylor_sine_polynomial: FAILED **");
        $finish;
    end

endmodule
